/* hdl/r4ps_pkg.sv */
// Shared types, constants and helpers for the 4D edge rotator.
package r4ps_pkg;

   localparam int COORD_W    = 16;
   localparam int FRAC_BITS  = 12;
   localparam int DIV_NUM_W  = 30;
   localparam int DIV_DEN_W  = 17;
   localparam int DIV_STAGES = DIV_NUM_W;
   localparam int LANES      = 6;

   localparam logic [1:0] MODE_PERSP = 2'd0;
   localparam logic [1:0] MODE_BAND  = 2'd1;
   localparam logic [1:0] MODE_CROSS = 2'd2;

   localparam logic [2:0] REG_LEFT  = 3'd0;
   localparam logic [2:0] REG_RIGHT = 3'd1;
   localparam logic [2:0] REG_MODE  = 3'd2;
   localparam logic [2:0] REG_SLICE = 3'd3;
   localparam logic [2:0] REG_EYE   = 3'd4;
   localparam logic [2:0] REG_BAND  = 3'd5;

   typedef logic signed [COORD_W-1:0] coord_type;

   localparam coord_type COORD_MAX = 16'sh7fff;
   localparam coord_type COORD_MIN = 16'sh8000;

   typedef struct packed {
      logic [1:0]      mode;
      logic            keep;
      logic            clip;
      logic            dpos_a;
      logic            dpos_b;
      coord_type [2:0] pa;
      coord_type [2:0] pb;
   } side_type;

   function automatic logic ovf_coord(input logic signed [27:0] x);
      return (x > 28'sd32767) || (x < -28'sd32768);
   endfunction

   function automatic coord_type sat_coord(input logic signed [27:0] x);
      coord_type r;
      if (x > 28'sd32767) begin
         r = COORD_MAX;
      end else if (x < -28'sd32768) begin
         r = COORD_MIN;
      end else begin
         r = coord_type'(x[15:0]);
      end
      return r;
   endfunction

endpackage

/* hdl/r4ps_rot.sv */
// Endpoint lane: two pipelined quaternion products that rotate one 4D point.
module r4ps_rot import r4ps_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] left_rotor,
   input  logic [63:0] right_rotor,
   input  coord_type   v_x,
   input  coord_type   v_y,
   input  coord_type   v_z,
   input  coord_type   v_w,
   output coord_type   r_x,
   output coord_type   r_y,
   output coord_type   r_z,
   output coord_type   r_w,
   output logic        clip
);

   coord_type l [4];
   coord_type rt [4];
   coord_type pv [4];
   logic signed [31:0] m1_in [4][4];
   logic signed [31:0] m1_ff [4][4];
   logic signed [33:0] s1 [4];
   logic signed [21:0] t_in [4];
   logic signed [21:0] t_ff [4];
   logic signed [37:0] m2_in [4][4];
   logic signed [37:0] m2_ff [4][4];
   logic signed [39:0] s2 [4];
   logic signed [27:0] o [4];
   coord_type r_in [4];
   coord_type r_ff [4];
   logic clip_in;
   logic clip_ff;

   assign pv[0] = v_w;
   assign pv[1] = v_x;
   assign pv[2] = v_y;
   assign pv[3] = v_z;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         l[i]  = coord_type'(left_rotor[63-16*i -: 16]);
         rt[i] = coord_type'(right_rotor[63-16*i -: 16]);
         for (int j = 0; j < 4; j++) begin
            m1_in[i][j] = l[i] * pv[j];
         end
      end
   end

   always_comb begin
      s1[0] = 34'(m1_ff[0][0]) - 34'(m1_ff[1][1]) - 34'(m1_ff[2][2]) - 34'(m1_ff[3][3]);
      s1[1] = 34'(m1_ff[0][1]) + 34'(m1_ff[1][0]) + 34'(m1_ff[2][3]) - 34'(m1_ff[3][2]);
      s1[2] = 34'(m1_ff[0][2]) - 34'(m1_ff[1][3]) + 34'(m1_ff[2][0]) + 34'(m1_ff[3][1]);
      s1[3] = 34'(m1_ff[0][3]) + 34'(m1_ff[1][2]) - 34'(m1_ff[2][1]) + 34'(m1_ff[3][0]);
      for (int i = 0; i < 4; i++) begin
         t_in[i] = 22'((s1[i] + 34'sd2048) >>> FRAC_BITS);
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            m2_in[i][j] = t_ff[i] * rt[j];
         end
      end
   end

   // The right rotor is conjugated, so its vector terms enter with flipped signs.
   always_comb begin
      s2[0] = 40'(m2_ff[0][0]) + 40'(m2_ff[1][1]) + 40'(m2_ff[2][2]) + 40'(m2_ff[3][3]);
      s2[1] = 40'(m2_ff[1][0]) - 40'(m2_ff[0][1]) - 40'(m2_ff[2][3]) + 40'(m2_ff[3][2]);
      s2[2] = 40'(m2_ff[2][0]) - 40'(m2_ff[0][2]) + 40'(m2_ff[1][3]) - 40'(m2_ff[3][1]);
      s2[3] = 40'(m2_ff[3][0]) - 40'(m2_ff[0][3]) - 40'(m2_ff[1][2]) + 40'(m2_ff[2][1]);
      for (int i = 0; i < 4; i++) begin
         o[i] = 28'((s2[i] + 40'sd2048) >>> FRAC_BITS);
      end
      r_in[0] = sat_coord(o[1]);
      r_in[1] = sat_coord(o[2]);
      r_in[2] = sat_coord(o[3]);
      r_in[3] = sat_coord(o[0]);
      clip_in = ovf_coord(o[0]) | ovf_coord(o[1]) | ovf_coord(o[2]) | ovf_coord(o[3]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff   <= m1_in;
         t_ff    <= t_in;
         m2_ff   <= m2_in;
         r_ff    <= r_in;
         clip_ff <= clip_in;
      end
   end

   assign r_x  = r_ff[0];
   assign r_y  = r_ff[1];
   assign r_z  = r_ff[2];
   assign r_w  = r_ff[3];
   assign clip = clip_ff;

endmodule

/* hdl/r4ps_div.sv */
// Divider lane: restoring division pipelined one quotient bit per stage.
module r4ps_div import r4ps_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic [DIV_NUM_W-1:0] quo
);

   logic [DIV_NUM_W-1:0] num_ff [DIV_STAGES];
   logic [DIV_DEN_W-1:0] den_ff [DIV_STAGES];
   logic [DIV_DEN_W-1:0] rem_ff [DIV_STAGES];
   logic [DIV_NUM_W-1:0] quo_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [DIV_NUM_W-1:0] num_src;
      logic [DIV_NUM_W-1:0] quo_src;
      logic [DIV_DEN_W-1:0] den_src;
      logic [DIV_DEN_W-1:0] rem_src;
      logic [DIV_DEN_W:0]   trial;
      logic                 fits;

      if (k == 0) begin : g_first
         assign num_src = num;
         assign den_src = den;
         assign rem_src = '0;
         assign quo_src = '0;
      end else begin : g_next
         assign num_src = num_ff[k-1];
         assign den_src = den_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign quo_src = quo_ff[k-1];
      end

      always_comb begin
         trial = {rem_src, num_src[DIV_NUM_W-1]};
         fits  = trial >= {1'b0, den_src};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[k] <= {num_src[DIV_NUM_W-2:0], 1'b0};
            den_ff[k] <= den_src;
            rem_ff[k] <= fits ? DIV_DEN_W'(trial - {1'b0, den_src}) : DIV_DEN_W'(trial);
            quo_ff[k] <= {quo_src[DIV_NUM_W-2:0], fits};
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule

/* hdl/r4ps_merge.sv */
// Merge stage: saturates the quotients, interpolates the crossing and selects the result.
module r4ps_merge import r4ps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  side_type             side,
   input  logic [DIV_NUM_W-1:0] quo [LANES],
   output logic                 out_valid,
   output coord_type            p_out [3],
   output coord_type            q_out [3],
   output logic                 is_point,
   output logic                 clipped
);

   coord_type cin [LANES];
   logic dp [LANES];
   coord_type per_in [LANES];
   coord_type per_ff [LANES];
   logic [LANES-1:0] pclip_vec;
   logic pclip_ff;
   logic [13:0] tq;
   logic signed [16:0] diff [3];
   logic signed [31:0] xp_in [3];
   logic signed [31:0] xp_ff [3];
   side_type side1_ff;
   logic v1_ff;

   logic xneg [3];
   logic [31:0] xmag [3];
   logic [19:0] qm [3];
   logic signed [20:0] step [3];
   logic signed [27:0] xsum [3];
   coord_type xres [3];
   logic [2:0] xclip;

   coord_type p_in [3];
   coord_type q_in [3];
   logic pt_in;
   logic clip_in;
   coord_type p_ff [3];
   coord_type q_ff [3];
   logic pt_ff;
   logic clip_ff;
   logic vout_ff;

   always_comb begin
      tq = quo[0][13:0];
      for (int i = 0; i < 3; i++) begin
         cin[i]   = side.pa[i];
         cin[i+3] = side.pb[i];
         dp[i]    = side.dpos_a;
         dp[i+3]  = side.dpos_b;
         diff[i]  = 17'($signed(side.pb[i])) - 17'($signed(side.pa[i]));
         xp_in[i] = diff[i] * $signed({1'b0, tq});
      end
      for (int i = 0; i < LANES; i++) begin
         pclip_vec[i] = 1'b0;
         if (!dp[i]) begin
            pclip_vec[i] = 1'b1;
            if (cin[i] == '0) begin
               per_in[i] = '0;
            end else if (cin[i][COORD_W-1]) begin
               per_in[i] = COORD_MIN;
            end else begin
               per_in[i] = COORD_MAX;
            end
         end else if (cin[i][COORD_W-1]) begin
            if (quo[i] > 30'd32768) begin
               pclip_vec[i] = 1'b1;
               per_in[i] = COORD_MIN;
            end else begin
               per_in[i] = coord_type'(16'(~quo[i][15:0] + 16'd1));
            end
         end else begin
            if (quo[i] > 30'd32767) begin
               pclip_vec[i] = 1'b1;
               per_in[i] = COORD_MAX;
            end else begin
               per_in[i] = coord_type'(quo[i][15:0]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side;
         per_ff   <= per_in;
         pclip_ff <= |pclip_vec;
         xp_ff    <= xp_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xneg[i]  = xp_ff[i][31];
         xmag[i]  = xneg[i] ? 32'(-xp_ff[i]) : 32'(xp_ff[i]);
         qm[i]    = 20'((xmag[i] + 32'd2048) >> FRAC_BITS);
         step[i]  = xneg[i] ? -$signed({1'b0, qm[i]}) : $signed({1'b0, qm[i]});
         xsum[i]  = 28'($signed(side1_ff.pa[i])) + 28'(step[i]);
         xres[i]  = sat_coord(xsum[i]);
         xclip[i] = ovf_coord(xsum[i]);
      end
      pt_in   = 1'b0;
      clip_in = side1_ff.clip;
      for (int i = 0; i < 3; i++) begin
         p_in[i] = side1_ff.pa[i];
         q_in[i] = side1_ff.pb[i];
      end
      case (side1_ff.mode)
         MODE_PERSP: begin
            for (int i = 0; i < 3; i++) begin
               p_in[i] = per_ff[i];
               q_in[i] = per_ff[i+3];
            end
            clip_in = side1_ff.clip | pclip_ff;
         end
         MODE_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               p_in[i] = xres[i];
               q_in[i] = '0;
            end
            pt_in   = 1'b1;
            clip_in = side1_ff.clip | (|xclip);
         end
         default: begin
            pt_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else if (en) begin
         vout_ff <= v1_ff & side1_ff.keep;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff    <= p_in;
         q_ff    <= q_in;
         pt_ff   <= pt_in;
         clip_ff <= clip_in;
      end
   end

   assign out_valid = vout_ff;
   assign p_out     = p_ff;
   assign q_out     = q_ff;
   assign is_point  = pt_ff;
   assign clipped   = clip_ff;

endmodule

/* hdl/rotate4d_project_slice.sv */
// Top level of the 4D edge rotator with perspective, band and crossing views.
// Throughput is one edge word per cycle; a stalled result stalls the whole pipeline.
// The pipeline runs through the two pipelined quaternion products, the 30-stage divider lanes and the merge stage.
// Synchronous active-high reset clears the valid pipeline and loads register defaults.
module rotate4d_project_slice import r4ps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // p_x, p_y, p_z, q_x, q_y, q_z
   output logic [1:0]   rsp_tuser,   // is_point, clipped
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [5:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   logic [63:0] left_ff;
   logic [63:0] right_ff;
   logic [1:0]  mode_ff;
   coord_type   slice_ff;
   coord_type   eye_ff;
   logic [14:0] band_ff;
   logic [2:0]  reg_idx;
   logic        wr_en;

   logic adv;
   logic [3:0] rv_ff;
   logic pv_ff;
   logic [DIV_STAGES-1:0] dv_ff;

   coord_type ra [4];
   coord_type rb [4];
   logic clip_a;
   logic clip_b;

   side_type side_in;
   side_type side_ff;
   side_type sd_ff [DIV_STAGES];
   logic [DIV_NUM_W-1:0] num_in [LANES];
   logic [DIV_DEN_W-1:0] den_in [LANES];
   logic [DIV_NUM_W-1:0] num_ff [LANES];
   logic [DIV_DEN_W-1:0] den_ff [LANES];
   logic [DIV_NUM_W-1:0] quo [LANES];

   logic signed [16:0] d_a;
   logic signed [16:0] d_b;
   coord_type cc [LANES];
   logic dpos [LANES];
   logic signed [16:0] dd [LANES];
   logic [15:0] cmag [LANES];
   logic signed [16:0] e1;
   logic signed [16:0] e2;
   logic signed [16:0] dw;
   logic [15:0] mag1;
   logic [15:0] dabs;
   logic [15:0] b1;
   logic [15:0] b2;
   logic keep_band;
   logic keep_cross;

   coord_type p_out [3];
   coord_type q_out [3];
   logic is_point;
   logic clipped;

   // Register file.
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[5:3];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= 64'h1000_0000_0000_0000;
         right_ff <= 64'h1000_0000_0000_0000;
         mode_ff  <= MODE_PERSP;
         slice_ff <= '0;
         eye_ff   <= 16'sd12288;
         band_ff  <= 15'd205;
      end else if (wr_en) begin
         case (reg_idx)
            REG_LEFT:  left_ff  <= csr_pwdata;
            REG_RIGHT: right_ff <= csr_pwdata;
            REG_MODE:  mode_ff  <= csr_pwdata[1:0];
            REG_SLICE: slice_ff <= coord_type'(csr_pwdata[15:0]);
            REG_EYE:   eye_ff   <= coord_type'(csr_pwdata[15:0]);
            REG_BAND:  band_ff  <= csr_pwdata[14:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LEFT:  csr_prdata = left_ff;
         REG_RIGHT: csr_prdata = right_ff;
         REG_MODE:  csr_prdata = {62'd0, mode_ff};
         REG_SLICE: csr_prdata = {{48{slice_ff[15]}}, slice_ff};
         REG_EYE:   csr_prdata = {{48{eye_ff[15]}}, eye_ff};
         REG_BAND:  csr_prdata = {49'd0, band_ff};
         default:   csr_prdata = '0;
      endcase
   end

   // Pipeline flow control.
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= '0;
         pv_ff <= 1'b0;
         dv_ff <= '0;
      end else if (adv) begin
         rv_ff <= {rv_ff[2:0], req_tvalid};
         pv_ff <= rv_ff[3];
         dv_ff <= {dv_ff[DIV_STAGES-2:0], pv_ff};
      end
   end

   r4ps_rot u_rot_a (
      .clock       (clock),
      .en          (adv),
      .left_rotor  (left_ff),
      .right_rotor (right_ff),
      .v_x         (coord_type'(req_tdata[15:0])),
      .v_y         (coord_type'(req_tdata[31:16])),
      .v_z         (coord_type'(req_tdata[47:32])),
      .v_w         (coord_type'(req_tdata[63:48])),
      .r_x         (ra[0]),
      .r_y         (ra[1]),
      .r_z         (ra[2]),
      .r_w         (ra[3]),
      .clip        (clip_a)
   );

   r4ps_rot u_rot_b (
      .clock       (clock),
      .en          (adv),
      .left_rotor  (left_ff),
      .right_rotor (right_ff),
      .v_x         (coord_type'(req_tdata[79:64])),
      .v_y         (coord_type'(req_tdata[95:80])),
      .v_z         (coord_type'(req_tdata[111:96])),
      .v_w         (coord_type'(req_tdata[127:112])),
      .r_x         (rb[0]),
      .r_y         (rb[1]),
      .r_z         (rb[2]),
      .r_w         (rb[3]),
      .clip        (clip_b)
   );

   // Divider operand setup for the selected view.
   always_comb begin
      d_a = 17'(eye_ff) - 17'(ra[3]);
      d_b = 17'(eye_ff) - 17'(rb[3]);
      for (int i = 0; i < 3; i++) begin
         cc[i]     = ra[i];
         cc[i+3]   = rb[i];
         dd[i]     = d_a;
         dd[i+3]   = d_b;
      end
      for (int i = 0; i < LANES; i++) begin
         dpos[i] = !dd[i][16] && (dd[i] != '0);
         cmag[i] = cc[i][15] ? 16'(-cc[i]) : 16'(cc[i]);
         if (dpos[i]) begin
            num_in[i] = DIV_NUM_W'({cmag[i], 13'd0}) + DIV_NUM_W'(dd[i][15:0]);
            den_in[i] = {dd[i][15:0], 1'b0};
         end else begin
            num_in[i] = '0;
            den_in[i] = DIV_DEN_W'(1);
         end
      end

      b1 = 16'((17'(ra[3]) - 17'(slice_ff)) < 0 ? (17'(slice_ff) - 17'(ra[3]))
                                                 : (17'(ra[3]) - 17'(slice_ff)));
      b2 = 16'((17'(rb[3]) - 17'(slice_ff)) < 0 ? (17'(slice_ff) - 17'(rb[3]))
                                                 : (17'(rb[3]) - 17'(slice_ff)));
      keep_band = (b1 < {1'b0, band_ff}) && (b2 < {1'b0, band_ff});

      e1   = 17'(slice_ff) - 17'(ra[3]);
      e2   = 17'(slice_ff) - 17'(rb[3]);
      dw   = 17'(rb[3]) - 17'(ra[3]);
      mag1 = e1[16] ? 16'(-e1) : 16'(e1);
      dabs = dw[16] ? 16'(-dw) : 16'(dw);
      keep_cross = (e1 != '0) && (e2 != '0) && (e1[16] != e2[16]);

      if (mode_ff == MODE_CROSS) begin
         num_in[0] = DIV_NUM_W'({mag1, 13'd0}) + DIV_NUM_W'(dabs);
         den_in[0] = (dabs == '0) ? DIV_DEN_W'(1) : {dabs, 1'b0};
      end

      side_in.mode   = mode_ff;
      side_in.clip   = clip_a | clip_b;
      side_in.dpos_a = dpos[0];
      side_in.dpos_b = dpos[3];
      for (int i = 0; i < 3; i++) begin
         side_in.pa[i] = ra[i];
         side_in.pb[i] = rb[i];
      end
      case (mode_ff)
         MODE_PERSP: side_in.keep = 1'b1;
         MODE_BAND:  side_in.keep = keep_band;
         MODE_CROSS: side_in.keep = keep_cross;
         default:    side_in.keep = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff <= side_in;
         num_ff  <= num_in;
         den_ff  <= den_in;
         sd_ff[0] <= side_ff;
         for (int k = 1; k < DIV_STAGES; k++) begin
            sd_ff[k] <= sd_ff[k-1];
         end
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_div
      r4ps_div u_div (
         .clock (clock),
         .en    (adv),
         .num   (num_ff[i]),
         .den   (den_ff[i]),
         .quo   (quo[i])
      );
   end

   r4ps_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (dv_ff[DIV_STAGES-1]),
      .side      (sd_ff[DIV_STAGES-1]),
      .quo       (quo),
      .out_valid (rsp_tvalid),
      .p_out     (p_out),
      .q_out     (q_out),
      .is_point  (is_point),
      .clipped   (clipped)
   );

   assign rsp_tdata = {q_out[2], q_out[1], q_out[0], p_out[2], p_out[1], p_out[0]};
   assign rsp_tuser = {clipped, is_point};

`ifndef SYNTHESIS
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");
   a_point_zero_q: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[95:48] == '0)
      else $error("crossing result carries a nonzero second point");
   a_point_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> mode_ff == MODE_CROSS)
      else $error("point result outside crossing mode");
   a_persp_segment: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (mode_ff == MODE_PERSP || mode_ff == MODE_BAND) |-> !rsp_tuser[0])
      else $error("segment view produced a point result");
`endif

endmodule
